/* rtl/core/scancode_line_editor_unit_assert.svh */
// Assertion macros shared by the checker of the scan code line editor.
`ifndef SCANCODE_LINE_EDITOR_UNIT_ASSERT_SVH
`define SCANCODE_LINE_EDITOR_UNIT_ASSERT_SVH

// Assertion sampled on clk, switched off while rst_n is low.
`define SLE_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion sampled on clk that also holds across reset.
`define SLE_ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/sle_pkg.sv */
// Shared types, constants and key tables of the scan code line editor.
package sle_pkg;

  localparam int LINE_SIZE_DEF = 128;
  localparam int TERMINALS_DEF = 3;
  localparam int TAB_WIDTH     = 4;
  localparam int MAX_RESULTS   = 4;
  localparam int TAB_SPACES    = (TAB_WIDTH < MAX_RESULTS) ? TAB_WIDTH : MAX_RESULTS;
  localparam int RUN_W         = $clog2(MAX_RESULTS);
  localparam int CMDQ_DEPTH    = 4;  // power of two, pointers wrap naturally
  localparam int CMDQ_PTR_W    = $clog2(CMDQ_DEPTH);
  localparam int MAP_SIZE      = 60;

  typedef enum logic [2:0] {
    ACT_STORE    = 3'd0,
    ACT_ERASE    = 3'd1,
    ACT_LINE_END = 3'd2,
    ACT_CLEAR    = 3'd3,
    ACT_SWITCH   = 3'd4
  } action_t;

  // One queued command: the first result word plus how many more follow.
  typedef struct packed {
    action_t          action;
    logic [7:0]       char_code;
    logic [6:0]       position;
    logic [1:0]       terminal_id;
    logic [RUN_W-1:0] extra;
  } cmd_t;

  localparam logic [7:0] SC_LSHIFT    = 8'h2A;
  localparam logic [7:0] SC_RSHIFT    = 8'h36;
  localparam logic [7:0] SC_CTRL      = 8'h1D;
  localparam logic [7:0] SC_ALT       = 8'h38;
  localparam logic [7:0] SC_CAPS      = 8'h3A;
  localparam logic [7:0] SC_TAB       = 8'h0F;
  localparam logic [7:0] SC_BKSP      = 8'h0E;
  localparam logic [7:0] SC_ENTER     = 8'h1C;
  localparam logic [7:0] SC_L         = 8'h26;
  localparam logic [7:0] SC_LSHIFT_UP = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_UP = 8'hB6;
  localparam logic [7:0] SC_ALT_UP    = 8'hB8;
  localparam logic [7:0] SC_CTRL_UP   = 8'h9D;
  localparam logic [7:0] SC_F1        = 8'h3B;
  localparam logic [7:0] SC_F2        = 8'h3C;
  localparam logic [7:0] SC_F3        = 8'h3D;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;

  localparam logic [7:0] KEY_BASE [MAP_SIZE] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h00,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3A,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00,
    8'h00, 8'h20, 8'h00, 8'h00
  };

  localparam logic [7:0] KEY_SHIFT [MAP_SIZE] = '{
    8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h00,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3B,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h00,
    8'h00, 8'h20, 8'h00, 8'h00
  };

endpackage

/* rtl/core/sle_front.sv */
// Front end: decodes scan codes, keeps key flags and line positions, issues commands.
module sle_front #(
  parameter int LINE_SIZE = sle_pkg::LINE_SIZE_DEF,
  parameter int TERMINALS = sle_pkg::TERMINALS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    in_scan_code,
  input  logic          in_push,
  output logic          in_full,
  output sle_pkg::cmd_t cmd_data,
  output logic          cmd_push,
  input  logic          cmd_full
);

  localparam int PW = $clog2(LINE_SIZE);
  localparam int TW = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
  localparam int NW = sle_pkg::RUN_W + 1;

  logic          caps_r, caps_nxt;
  logic          lshift_r, lshift_nxt;
  logic          rshift_r, rshift_nxt;
  logic          ctrl_r, ctrl_nxt;
  logic          alt_r, alt_nxt;
  logic [TW-1:0] term_r, term_nxt;
  logic [PW-1:0] pos_r [TERMINALS];
  logic [PW-1:0] pos_nxt;

  logic          accept;
  logic          emit;
  logic [PW-1:0] cur_pos;
  logic [PW-1:0] room;
  logic [NW-1:0] tab_n;
  logic [7:0]    f_off;
  logic [1:0]    f_target;
  logic [5:0]    key_idx;
  logic [7:0]    key_base;
  logic [7:0]    key_shift;
  logic          shifted;
  logic          is_letter;
  logic          use_shift;
  logic          key_ok;
  logic [7:0]    key_char;

  function automatic logic [6:0] pos7(input logic [PW-1:0] p);
    logic [PW+6:0] w;
    w = {7'd0, p};
    return w[6:0];
  endfunction

  assign accept   = in_push && !cmd_full;
  assign in_full  = cmd_full;
  assign cur_pos  = pos_r[term_r];

  // tab fills up to LINE_SIZE-2, capped at the run length
  assign room     = PW'(LINE_SIZE - 2) - cur_pos;
  assign tab_n    = (room < PW'(sle_pkg::TAB_SPACES)) ? NW'(room) : NW'(sle_pkg::TAB_SPACES);

  assign f_off    = in_scan_code - sle_pkg::SC_F1;
  assign f_target = f_off[1:0];

  assign key_idx   = in_scan_code[5:0];
  assign key_base  = (in_scan_code < 8'(sle_pkg::MAP_SIZE)) ? sle_pkg::KEY_BASE[key_idx] : 8'd0;
  assign key_shift = (in_scan_code < 8'(sle_pkg::MAP_SIZE)) ? sle_pkg::KEY_SHIFT[key_idx] : 8'd0;
  assign shifted   = lshift_r || rshift_r;
  assign is_letter = key_base inside {[sle_pkg::CH_LOWER_A:sle_pkg::CH_LOWER_Z],
                                      [sle_pkg::CH_UPPER_A:sle_pkg::CH_UPPER_Z]};
  assign use_shift = is_letter ? (caps_r ^ shifted) : shifted;
  assign key_char  = use_shift ? key_shift : key_base;
  assign key_ok    = (cur_pos < PW'(LINE_SIZE - 1)) && (key_base != 8'd0);

  always_comb begin
    caps_nxt   = caps_r;
    lshift_nxt = lshift_r;
    rshift_nxt = rshift_r;
    ctrl_nxt   = ctrl_r;
    alt_nxt    = alt_r;
    term_nxt   = term_r;
    pos_nxt    = cur_pos;
    emit       = 1'b0;
    cmd_data   = '0;
    cmd_data.action      = sle_pkg::ACT_STORE;
    cmd_data.position    = pos7(cur_pos);
    cmd_data.terminal_id = 2'(term_r);
    case (in_scan_code)
      sle_pkg::SC_LSHIFT:    lshift_nxt = 1'b1;
      sle_pkg::SC_RSHIFT:    rshift_nxt = 1'b1;
      sle_pkg::SC_CTRL:      ctrl_nxt   = 1'b1;
      sle_pkg::SC_ALT:       alt_nxt    = 1'b1;
      sle_pkg::SC_CAPS:      caps_nxt   = !caps_r;
      sle_pkg::SC_LSHIFT_UP: lshift_nxt = 1'b0;
      sle_pkg::SC_RSHIFT_UP: rshift_nxt = 1'b0;
      sle_pkg::SC_ALT_UP:    alt_nxt    = 1'b0;
      sle_pkg::SC_CTRL_UP:   ctrl_nxt   = 1'b0;
      sle_pkg::SC_TAB: begin
        if (cur_pos < PW'(LINE_SIZE - 2)) begin
          emit               = 1'b1;
          cmd_data.char_code = sle_pkg::CH_SPACE;
          cmd_data.extra     = sle_pkg::RUN_W'(tab_n - NW'(1));
          pos_nxt            = cur_pos + PW'(tab_n);
        end
      end
      sle_pkg::SC_BKSP: begin
        if (cur_pos != '0) begin
          emit              = 1'b1;
          pos_nxt           = cur_pos - PW'(1);
          cmd_data.action   = sle_pkg::ACT_ERASE;
          cmd_data.position = pos7(pos_nxt);
        end
      end
      sle_pkg::SC_ENTER: begin
        emit               = 1'b1;
        cmd_data.action    = sle_pkg::ACT_LINE_END;
        cmd_data.char_code = sle_pkg::CH_NEWLINE;
        cmd_data.position  = (cur_pos > PW'(LINE_SIZE - 1)) ? pos7(PW'(LINE_SIZE - 1))
                                                             : pos7(cur_pos);
        pos_nxt            = '0;
      end
      sle_pkg::SC_F1, sle_pkg::SC_F2, sle_pkg::SC_F3: begin
        if (alt_r && (int'(f_target) < TERMINALS)) begin
          emit                 = 1'b1;
          term_nxt             = TW'(f_target);
          cmd_data.action      = sle_pkg::ACT_SWITCH;
          cmd_data.position    = '0;
          cmd_data.terminal_id = f_target;
        end
      end
      sle_pkg::SC_L: begin
        if (ctrl_r) begin
          emit              = 1'b1;
          cmd_data.action   = sle_pkg::ACT_CLEAR;
          cmd_data.position = '0;
        end else if (key_ok) begin
          emit               = 1'b1;
          cmd_data.char_code = key_char;
          pos_nxt            = cur_pos + PW'(1);
        end
      end
      default: begin
        if (key_ok) begin
          emit               = 1'b1;
          cmd_data.char_code = key_char;
          pos_nxt            = cur_pos + PW'(1);
        end
      end
    endcase
  end

  assign cmd_push = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      caps_r   <= 1'b0;
      lshift_r <= 1'b0;
      rshift_r <= 1'b0;
      ctrl_r   <= 1'b0;
      alt_r    <= 1'b0;
      term_r   <= '0;
      for (int i = 0; i < TERMINALS; i++) begin
        pos_r[i] <= '0;
      end
    end else if (accept) begin
      caps_r         <= caps_nxt;
      lshift_r       <= lshift_nxt;
      rshift_r       <= rshift_nxt;
      ctrl_r         <= ctrl_nxt;
      alt_r          <= alt_nxt;
      term_r         <= term_nxt;
      pos_r[term_r]  <= pos_nxt;
    end
  end

endmodule

/* rtl/core/sle_cmd_fifo.sv */
// Short command queue between the decode front end and the result back end.
module sle_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sle_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output sle_pkg::cmd_t rdata,
  output logic          empty
);

  localparam int PTR_W = sle_pkg::CMDQ_PTR_W;

  sle_pkg::cmd_t    mem_r [sle_pkg::CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (PTR_W + 1)'(sle_pkg::CMDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + (PTR_W + 1)'(1);
        2'b01:   cnt_r <= cnt_r - (PTR_W + 1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

/* rtl/core/sle_back.sv */
// Back end: expands queued commands into result words, one per cycle while out_pop takes them.
module sle_back (
  input  logic          clk,
  input  logic          rst_n,
  input  sle_pkg::cmd_t q_data,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          out_empty,
  input  logic          out_pop,
  output logic [2:0]    out_action,
  output logic [7:0]    out_char_code,
  output logic [6:0]    out_position,
  output logic [1:0]    out_terminal_id,
  output logic          out_last_of_run
);

  sle_pkg::cmd_t cur_r, cur_nxt;
  logic          valid_r, valid_nxt;
  logic          last;
  logic          load;

  assign last = (cur_r.extra == '0);
  // refill when idle, or when the last word of the current run leaves
  assign load  = !q_empty && (!valid_r || (out_pop && last));
  assign q_pop = load;

  always_comb begin
    cur_nxt   = cur_r;
    valid_nxt = valid_r;
    if (load) begin
      cur_nxt   = q_data;
      valid_nxt = 1'b1;
    end else if (valid_r && out_pop) begin
      if (!last) begin
        cur_nxt.extra    = cur_r.extra - sle_pkg::RUN_W'(1);
        cur_nxt.position = cur_r.position + 7'd1;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign out_empty       = !valid_r;
  assign out_action      = cur_r.action;
  assign out_char_code   = cur_r.char_code;
  assign out_position    = cur_r.position;
  assign out_terminal_id = cur_r.terminal_id;
  assign out_last_of_run = last;

endmodule

/* rtl/core/scancode_line_editor_unit.sv */
// A pushed scan code word passes through the command queue and the back end's run register.
// Throughput: one scan code per cycle while the command queue is not full; a tab gives one
//   result word per space (up to 4), one per cycle from the back end's run register while out_pop takes them.
// The four-entry command queue lets the front keep taking scan codes during a tab run.
// Reset: synchronous, active low; flags, active terminal, line positions and queues clear.
// Top level of the scan code line editor.
module scancode_line_editor_unit #(
  parameter int LINE_SIZE = sle_pkg::LINE_SIZE_DEF,
  parameter int TERMINALS = sle_pkg::TERMINALS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_scan_code,
  input  logic       in_push,
  output logic       in_full,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [2:0] out_action,
  output logic [7:0] out_char_code,
  output logic [6:0] out_position,
  output logic [1:0] out_terminal_id,
  output logic       out_last_of_run
);

  // front -> queue
  sle_pkg::cmd_t fq_data;
  logic          fq_push;
  logic          fq_full;
  // queue -> back
  sle_pkg::cmd_t qb_data;
  logic          qb_pop;
  logic          qb_empty;

  // Front end: every scan code word is classified in its accept cycle. Key
  // flags, the active terminal and the per-terminal line positions update
  // here, so the next scan code sees them at once. Only codes that produce
  // results leave a command; a tab command carries its whole space run.
  sle_front #(
    .LINE_SIZE (LINE_SIZE),
    .TERMINALS (TERMINALS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_scan_code (in_scan_code),
    .in_push      (in_push),
    .in_full      (in_full),
    .cmd_data     (fq_data),
    .cmd_push     (fq_push),
    .cmd_full     (fq_full)
  );

  // Decoupling queue: input backpressure only when it is full.
  sle_cmd_fifo u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .wdata (fq_data),
    .full  (fq_full),
    .pop   (qb_pop),
    .rdata (qb_data),
    .empty (qb_empty)
  );

  // Back end: its run register drives the result ports directly and reloads
  // from the queue in the same cycle the last word of a run is popped.
  sle_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_data          (qb_data),
    .q_empty         (qb_empty),
    .q_pop           (qb_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_action      (out_action),
    .out_char_code   (out_char_code),
    .out_position    (out_position),
    .out_terminal_id (out_terminal_id),
    .out_last_of_run (out_last_of_run)
  );

endmodule

/* rtl/core/sle_checker.sv */
// Port-level checker of the scan code line editor and its bind.
`include "scancode_line_editor_unit_assert.svh"

module sle_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic [2:0] out_action,
  input logic [7:0] out_char_code,
  input logic [6:0] out_position,
  input logic       out_last_of_run
);

  // reset drains both sides
  `SLE_ASSERT_ANY(a_reset_clears, !rst_n |=> (out_empty && !in_full), "reset did not clear")

  // a waiting result word holds until taken
  `SLE_ASSERT_RUN(a_result_holds, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_char_code) && $stable(out_position)), "waiting result changed")

  // only character stores come in runs
  `SLE_ASSERT_RUN(a_single_word, (!out_empty && out_action != sle_pkg::ACT_STORE) |-> out_last_of_run, "non-store word not last")

  // inside a run the next space follows at the next slot
  `SLE_ASSERT_RUN(a_run_steps, (!out_empty && out_pop && !out_last_of_run) |=> (!out_empty && out_char_code == sle_pkg::CH_SPACE && out_position == 7'($past(out_position) + 7'd1)), "run broken")

endmodule

bind scancode_line_editor_unit sle_checker u_sle_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_full         (in_full),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_action      (out_action),
  .out_char_code   (out_char_code),
  .out_position    (out_position),
  .out_last_of_run (out_last_of_run)
);
